### rtl/sln_pkg.sv
// ----------------------------------------------------------------------------
// sln_pkg: shared definitions of the sample length normaliser
// Default widths and configuration register indexes used by the interfaces
// and the top level.
// ----------------------------------------------------------------------------
package sln_pkg;

  // Default widths of samples, lengths and position fraction.
  localparam int unsigned DefaultSampleBits = 16;
  localparam int unsigned DefaultLengthBits = 16;
  localparam int unsigned DefaultFracBits   = 16;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegInLength  = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegOutLength = 1'd1;

endpackage

### rtl/sln_sample_if.sv
// ----------------------------------------------------------------------------
// sln_sample_if: input sample channel
// Valid/ready channel carrying one signed sample per word.
// ----------------------------------------------------------------------------
interface sln_sample_if
  import sln_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DefaultSampleBits
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/sln_result_if.sv
// ----------------------------------------------------------------------------
// sln_result_if: normalised result channel
// Valid/ready channel carrying one normalised sample and its flags per word.
// ----------------------------------------------------------------------------
interface sln_result_if
  import sln_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DefaultSampleBits,
  parameter int unsigned LENGTH_BITS = DefaultLengthBits
);
  logic                          valid;
  logic                          ready;
  logic        [LENGTH_BITS-1:0] out_index;
  logic signed [SAMPLE_BITS-1:0] value;
  logic                          inserted;
  logic                          last_of_run;

  modport source (output valid, output out_index, output value, output inserted,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_index, input value, input inserted,
                  input last_of_run, output ready);
endinterface

### rtl/sample_length_normalizer_top.sv
// ----------------------------------------------------------------------------
// sample_length_normalizer_top: record length normaliser
// Drops samples (shrink) or inserts floor averages (stretch) so that a record
// of in_length samples approaches out_length samples.
//
//   Channel   Direction  Word / access
//   in_i      sink       sample, accepted on valid && ready
//   res_o     source     out_index, value, inserted, last_of_run
//   cfg_*     write      cfg_we_i, cfg_idx_i, cfg_wdata_i, one register per edge
//
// Pass-through and shrink take one sample per cycle while the result port
// accepts; a stretched sample that gets an inserted average gives two words,
// which share the single result port. A sample waits in the input register
// until its words enter a two-word result queue. After every configuration
// write a restoring divider forms the interval (it is cleared when the two
// lengths match), and no sample is processed meanwhile. Reset is asynchronous
// and needs no clearing pass. A stalled result port stops processing once the
// queue is full.
// ----------------------------------------------------------------------------
module sample_length_normalizer_top
  import sln_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = DefaultSampleBits,
  parameter int unsigned LENGTH_BITS = DefaultLengthBits,
  parameter int unsigned FRAC_BITS   = DefaultFracBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [LENGTH_BITS-1:0] cfg_wdata_i,
  sln_sample_if.sink             in_i,
  sln_result_if.source           res_o
);

  localparam int unsigned PosBits = LENGTH_BITS + FRAC_BITS;
  localparam int unsigned CntBits = $clog2(PosBits + 1);
  localparam logic [PosBits-1:0] PosOne =
    {{(LENGTH_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PosBits-1:0]     PosMax = '1;
  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  typedef struct packed {
    logic        [LENGTH_BITS-1:0] out_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          inserted;
    logic                          last_of_run;
  } res_t;

  // Configuration registers.
  logic [LENGTH_BITS-1:0] in_length_q, out_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_length_q  <= LENGTH_BITS'(1);
      out_length_q <= LENGTH_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInLength:  in_length_q  <= cfg_wdata_i;
        RegOutLength: out_length_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Effective input length and the length difference.
  logic [LENGTH_BITS-1:0] eff_len, len_diff;

  always_comb begin
    eff_len  = (in_length_q == '0) ? LENGTH_BITS'(1) : in_length_q;
    len_diff = (eff_len > out_length_q) ? (eff_len - out_length_q)
                                        : (out_length_q - eff_len);
  end

  // Restoring divider: interval = (eff_len << FRAC_BITS) / len_diff, one
  // quotient bit per cycle, restarted after every configuration write.
  logic                   div_start_q, div_busy_q;
  logic [CntBits-1:0]     div_cnt_q;
  logic [PosBits-1:0]     div_num_q, div_res_q;
  logic [LENGTH_BITS:0]   div_rem_q;
  logic [LENGTH_BITS-1:0] div_den_q;
  logic [LENGTH_BITS:0]   div_rem_sh, div_rem_d;
  logic                   div_ge, div_busy;

  assign div_busy = div_start_q | div_busy_q;

  always_comb begin
    div_rem_sh = {div_rem_q[LENGTH_BITS-1:0], div_num_q[PosBits-1]};
    div_ge     = div_rem_sh >= {1'b0, div_den_q};
    div_rem_d  = div_ge ? (div_rem_sh - {1'b0, div_den_q}) : div_rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_start_q <= 1'b0;
      div_busy_q  <= 1'b0;
      div_cnt_q   <= '0;
      div_res_q   <= '0;
    end else begin
      div_start_q <= cfg_we_i;
      if (div_start_q) begin
        if (len_diff == '0) begin
          div_res_q  <= '0;
          div_busy_q <= 1'b0;
        end else begin
          div_busy_q <= 1'b1;
          div_cnt_q  <= CntBits'(PosBits);
        end
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - CntBits'(1);
        if (div_cnt_q == CntBits'(1)) begin
          div_busy_q <= 1'b0;
          div_res_q  <= {div_num_q[PosBits-2:0], div_ge};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start_q) begin
      div_num_q <= {eff_len, {FRAC_BITS{1'b0}}};
      div_rem_q <= '0;
      div_den_q <= len_diff;
    end else if (div_busy_q) begin
      div_num_q <= {div_num_q[PosBits-2:0], div_ge};
      div_rem_q <= div_rem_d;
    end
  end

  // Input register.
  logic                          in_vld_q;
  logic signed [SAMPLE_BITS-1:0] in_smp_q;
  logic                          fire;

  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_smp_q <= in_i.sample;
    end
  end

  // Record state.
  logic        [LENGTH_BITS-1:0] in_count_q, out_count_q;
  logic        [PosBits-1:0]     next_pos_q, interval_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;

  // Processing of the sample in the input register; a new record takes the
  // freshly computed interval, restarts the position at one and clears index and history.
  logic                          rec_start, mode_eq, mode_shrink, drop, ins;
  logic        [LENGTH_BITS-1:0] cnt_now, idx0, idx1, idx2, in_count_d;
  logic        [PosBits-1:0]     pos_now, ivl_now, pos_adv, next_pos_d;
  logic        [PosBits:0]       pos_sum;
  logic signed [SAMPLE_BITS-1:0] prev_now, avg;
  logic signed [SAMPLE_BITS:0]   smp_sum;
  logic        [LENGTH_BITS:0]   in_count_inc;
  logic        [1:0]             n_res;
  res_t                          r0, r1;

  always_comb begin
    rec_start   = (in_count_q == '0);
    pos_now     = rec_start ? PosOne : next_pos_q;
    ivl_now     = rec_start ? div_res_q : interval_q;
    cnt_now     = rec_start ? '0 : out_count_q;
    prev_now    = rec_start ? '0 : prev_q;
    mode_eq     = (eff_len == out_length_q);
    mode_shrink = (eff_len > out_length_q);
    drop        = (in_count_q == pos_now[PosBits-1:FRAC_BITS]);
    ins         = ({in_count_q, {FRAC_BITS{1'b0}}} >= pos_now);

    pos_sum = {1'b0, pos_now} + {1'b0, ivl_now};
    pos_adv = pos_sum[PosBits] ? PosMax : pos_sum[PosBits-1:0];

    smp_sum = {prev_now[SAMPLE_BITS-1], prev_now} + {in_smp_q[SAMPLE_BITS-1], in_smp_q};
    avg     = smp_sum[SAMPLE_BITS:1];

    idx0 = cnt_now;
    idx1 = (idx0 == LenMax) ? idx0 : idx0 + LENGTH_BITS'(1);
    idx2 = (idx1 == LenMax) ? idx1 : idx1 + LENGTH_BITS'(1);

    r0.out_index   = idx0;
    r0.value       = in_smp_q;
    r0.inserted    = 1'b0;
    r0.last_of_run = 1'b1;
    r1.out_index   = idx1;
    r1.value       = avg;
    r1.inserted    = 1'b1;
    r1.last_of_run = 1'b1;
    next_pos_d     = pos_now;

    if (mode_eq) begin
      n_res = 2'd1;
    end else if (mode_shrink) begin
      n_res = drop ? 2'd0 : 2'd1;
      if (drop) begin
        next_pos_d = pos_adv;
      end
    end else begin
      n_res          = ins ? 2'd2 : 2'd1;
      r0.last_of_run = !ins;
      if (ins) begin
        next_pos_d = pos_adv;
      end
    end

    in_count_inc = {1'b0, in_count_q} + (LENGTH_BITS + 1)'(1);
    in_count_d   = (in_count_inc >= {1'b0, eff_len}) ? '0 : in_count_inc[LENGTH_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q  <= '0;
      out_count_q <= '0;
      next_pos_q  <= PosOne;
      interval_q  <= '0;
      prev_q      <= '0;
    end else if (fire) begin
      in_count_q  <= in_count_d;
      out_count_q <= (n_res == 2'd2) ? idx2 : ((n_res == 2'd1) ? idx1 : idx0);
      next_pos_q  <= next_pos_d;
      interval_q  <= ivl_now;
      prev_q      <= in_smp_q;
    end
  end

  // Two-word result queue; slot 0 drives the result port.
  res_t       slot0_q, slot1_q, slot0_d, slot1_d;
  logic [1:0] res_cnt_q, res_cnt_d, rem_cnt, push_n;
  logic [2:0] need;
  logic       pop;

  assign pop         = res_o.valid && res_o.ready;
  assign rem_cnt     = res_cnt_q - {1'b0, pop};
  assign need        = {1'b0, rem_cnt} + {1'b0, n_res};
  assign fire        = in_vld_q && !div_busy && (need <= 3'd2);
  assign push_n      = fire ? n_res : 2'd0;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push_n != 2'd0) begin
      if (rem_cnt == 2'd0) begin
        slot0_d = r0;
        slot1_d = r1;
      end else begin
        slot1_d = r0;
      end
    end
    res_cnt_d = rem_cnt + push_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= '0;
    end else begin
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign res_o.valid       = (res_cnt_q != 2'd0);
  assign res_o.out_index   = slot0_q.out_index;
  assign res_o.value       = slot0_q.value;
  assign res_o.inserted    = slot0_q.inserted;
  assign res_o.last_of_run = slot0_q.last_of_run;

  // Assertions.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q != 2'd3)
    else $error("result queue holds more than two words");

  a_no_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> !div_busy)
    else $error("sample processed while the interval is being computed");

  a_cfg_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> div_busy)
    else $error("configuration write did not restart the divider");

  a_inserted_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.inserted) |-> res_o.last_of_run)
    else $error("inserted average is not the last word of its sample");

endmodule
